// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the block.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LOL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LOL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/lol_pkg.sv =====
// Package of the recency order list: sizes, opcodes and the result type.
// Used by the interfaces, the sequencer, the top level and the checker.
package lol_pkg;

  localparam int unsigned ENTRIES = 256;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned LINK_W  = IDX_W + 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(ENTRIES);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_TOUCH  = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [LINK_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } lol_ram_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] head_entry;
    logic [IDX_W-1:0] tail_entry;
    logic [CNT_W-1:0] entry_count;
    logic             list_empty;
    logic             misuse_flag;
  } lol_result_t;

endpackage

// ===== rtl/lol_if.sv =====
// Valid/ready channel interfaces for the command and result items.
// Depends on lol_pkg for the field widths.
interface lol_in_if import lol_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [IDX_W-1:0] entry_index;

  modport source (output valid, output opcode, output entry_index, input ready);
  modport sink (input valid, input opcode, input entry_index, output ready);
endinterface

interface lol_out_if import lol_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] head_entry;
  logic [IDX_W-1:0] tail_entry;
  logic [CNT_W-1:0] entry_count;
  logic             list_empty;
  logic             misuse_flag;

  modport source (output valid, output head_entry, output tail_entry, output entry_count,
                  output list_empty, output misuse_flag, input ready);
  modport sink (input valid, input head_entry, input tail_entry, input entry_count,
                input list_empty, input misuse_flag, output ready);
endinterface

// ===== rtl/lol_link_ram.sv =====
// Simple dual port RAM with one write port and one registered read port.
// No dependencies; used for the previous and next link stores.
module lol_link_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 9
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lol_seq.sv =====
// Sequencer: reads an entry's links, rewrites neighbor and head links, keeps
// head, tail, count and membership bits. Depends on lol_pkg.
module lol_seq import lol_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  logic [1:0]        cmd_opcode_i,
  input  logic [IDX_W-1:0]  cmd_entry_i,
  output lol_ram_req_t      prev_req_o,
  output lol_ram_req_t      next_req_o,
  input  logic [LINK_W-1:0] prev_rdata_i,
  input  logic [LINK_W-1:0] next_rdata_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output lol_result_t       res_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UNLINK = 3'd1;
  localparam logic [2:0] ST_LINK_E = 3'd2;
  localparam logic [2:0] ST_LINK_H = 3'd3;
  localparam logic [2:0] ST_RESP   = 3'd4;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_INS   = 2'd1;
  localparam logic [1:0] ACT_TOUCH = 2'd2;
  localparam logic [1:0] ACT_REM   = 2'd3;

  logic [2:0]         state_q, state_d;
  logic [1:0]         act_q, act_d;
  logic [IDX_W-1:0]   entry_q;
  logic               misuse_q, misuse_d;
  logic [LINK_W-1:0]  head_q, head_d;
  logic [LINK_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [ENTRIES-1:0] in_list_q;
  logic               accept;
  logic               finish;
  logic               listed;
  logic [LINK_W-1:0]  entry_link;

  assign accept      = cmd_valid_i && cmd_ready_o;
  assign cmd_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);
  assign finish      = res_valid_o && res_ready_i;
  assign listed      = in_list_q[cmd_entry_i];
  assign entry_link  = {1'b0, entry_q};

  always_comb begin
    act_d    = ACT_NONE;
    misuse_d = 1'b0;
    case (cmd_opcode_i)
      OP_INSERT: begin
        if (listed) begin
          misuse_d = 1'b1;
        end else begin
          act_d = ACT_INS;
        end
      end
      OP_TOUCH: begin
        if (!listed) begin
          misuse_d = 1'b1;
        end else if ({1'b0, cmd_entry_i} != head_q) begin
          act_d = ACT_TOUCH;
        end
      end
      OP_REMOVE: begin
        if (listed) begin
          act_d = ACT_REM;
        end else begin
          misuse_d = 1'b1;
        end
      end
      default: begin
        misuse_d = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (act_d)
            ACT_INS:   state_d = ST_LINK_E;
            ACT_TOUCH: state_d = ST_UNLINK;
            ACT_REM:   state_d = ST_UNLINK;
            default:   state_d = ST_RESP;
          endcase
        end
      end
      ST_UNLINK: state_d = (act_q == ACT_TOUCH) ? ST_LINK_E : ST_RESP;
      ST_LINK_E: state_d = ST_LINK_H;
      ST_LINK_H: state_d = ST_RESP;
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    prev_req_o       = '0;
    next_req_o       = '0;
    prev_req_o.re    = accept;
    prev_req_o.raddr = cmd_entry_i;
    next_req_o.re    = accept;
    next_req_o.raddr = cmd_entry_i;
    case (state_q)
      ST_UNLINK: begin
        next_req_o.we    = !prev_rdata_i[IDX_W];
        next_req_o.waddr = prev_rdata_i[IDX_W-1:0];
        next_req_o.wdata = next_rdata_i;
        prev_req_o.we    = !next_rdata_i[IDX_W];
        prev_req_o.waddr = next_rdata_i[IDX_W-1:0];
        prev_req_o.wdata = prev_rdata_i;
      end
      ST_LINK_E: begin
        prev_req_o.we    = 1'b1;
        prev_req_o.waddr = entry_q;
        prev_req_o.wdata = NIL_LINK;
        next_req_o.we    = 1'b1;
        next_req_o.waddr = entry_q;
        next_req_o.wdata = head_q;
      end
      ST_LINK_H: begin
        prev_req_o.we    = !head_q[IDX_W];
        prev_req_o.waddr = head_q[IDX_W-1:0];
        prev_req_o.wdata = entry_link;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    case (act_q)
      ACT_INS: begin
        head_d  = entry_link;
        tail_d  = head_q[IDX_W] ? entry_link : tail_q;
        count_d = count_q + CNT_W'(1);
      end
      ACT_TOUCH: begin
        head_d = entry_link;
        tail_d = next_rdata_i[IDX_W] ? prev_rdata_i : tail_q;
      end
      ACT_REM: begin
        head_d  = prev_rdata_i[IDX_W] ? next_rdata_i : head_q;
        tail_d  = next_rdata_i[IDX_W] ? prev_rdata_i : tail_q;
        count_d = count_q - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.list_empty  = head_d[IDX_W];
    res_o.head_entry  = head_d[IDX_W] ? '0 : head_d[IDX_W-1:0];
    res_o.tail_entry  = head_d[IDX_W] ? '0 : tail_d[IDX_W-1:0];
    res_o.entry_count = count_d;
    res_o.misuse_flag = misuse_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      act_q     <= ACT_NONE;
      misuse_q  <= 1'b0;
      head_q    <= NIL_LINK;
      tail_q    <= NIL_LINK;
      count_q   <= '0;
      in_list_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        act_q    <= act_d;
        misuse_q <= misuse_d;
      end
      if (finish) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
        if (act_q == ACT_INS) begin
          in_list_q[entry_q] <= 1'b1;
        end else if (act_q == ACT_REM) begin
          in_list_q[entry_q] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= cmd_entry_i;
    end
  end

endmodule

// ===== rtl/lru_order_list.sv =====
// Top level of the recency order list: link RAMs, sequencer, result register.
// Depends on lol_pkg, lol_if, lol_link_ram and lol_seq.
//
// Usage: req_i carries one command item (opcode, entry_index); rsp_o returns
// exactly one result item per command with the list's head, tail, count,
// empty flag and a misuse flag, all taken after the command's update.
// Commands are handled one at a time. The link stores are two RAMs with a
// registered read; a touch or remove reads the entry's links in the accept
// cycle, then rewrites its neighbors' links and, for a touch, the entry's
// own links and the old head's previous link. An ignored command or a touch
// of the head goes from the accept straight to ST_RESP; a remove passes
// ST_UNLINK, an insert ST_LINK_E and ST_LINK_H, and a touch all of these;
// req_i is ready again only once the result is in the output register.
// A result waits in an output register; the next command is taken while it
// waits, and its own result is held back until rsp_o takes the first.
// Reset empties the list and clears all membership bits at once; the link
// RAMs are not cleared and need no sweep, since a link is read only for a
// listed entry. Misused commands change nothing and set misuse_flag.
module lru_order_list import lol_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  lol_in_if.sink    req_i,
  lol_out_if.source rsp_o
);

  lol_ram_req_t      prev_req, next_req;
  logic [LINK_W-1:0] prev_rdata, next_rdata;
  logic              res_valid, res_ready;
  lol_result_t       res;
  lol_result_t       out_q;
  logic              out_valid_q;

  lol_link_ram #(.DEPTH(ENTRIES), .WIDTH(LINK_W)) u_prev_ram (
    .clk_i  (clk_i),
    .we_i   (prev_req.we),
    .waddr_i(prev_req.waddr),
    .wdata_i(prev_req.wdata),
    .re_i   (prev_req.re),
    .raddr_i(prev_req.raddr),
    .rdata_o(prev_rdata)
  );

  lol_link_ram #(.DEPTH(ENTRIES), .WIDTH(LINK_W)) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (next_req.we),
    .waddr_i(next_req.waddr),
    .wdata_i(next_req.wdata),
    .re_i   (next_req.re),
    .raddr_i(next_req.raddr),
    .rdata_o(next_rdata)
  );

  lol_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (req_i.valid),
    .cmd_ready_o (req_i.ready),
    .cmd_opcode_i(req_i.opcode),
    .cmd_entry_i (req_i.entry_index),
    .prev_req_o  (prev_req),
    .next_req_o  (next_req),
    .prev_rdata_i(prev_rdata),
    .next_rdata_i(next_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.head_entry  = out_q.head_entry;
  assign rsp_o.tail_entry  = out_q.tail_entry;
  assign rsp_o.entry_count = out_q.entry_count;
  assign rsp_o.list_empty  = out_q.list_empty;
  assign rsp_o.misuse_flag = out_q.misuse_flag;

endmodule

// ===== rtl/lol_checker.sv =====
// Port-level checks of the recency order list, bound to the top level.
// Depends on lol_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lol_checker import lol_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [IDX_W-1:0] head_entry_i,
  input logic [IDX_W-1:0] tail_entry_i,
  input logic [CNT_W-1:0] entry_count_i,
  input logic             list_empty_i,
  input logic             misuse_flag_i
);

  `LOL_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_i, !in_ready_i)
  `LOL_ASSERT_IMP(a_empty_count, out_valid_i, list_empty_i == (entry_count_i == '0))
  `LOL_ASSERT_IMP(a_empty_ends, out_valid_i && list_empty_i,
                  head_entry_i == '0 && tail_entry_i == '0)
  `LOL_ASSERT_NEXT(a_stall_hold, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(head_entry_i) && $stable(tail_entry_i) &&
                   $stable(entry_count_i) && $stable(misuse_flag_i))

endmodule

bind lru_order_list lol_checker u_lol_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .head_entry_i (rsp_o.head_entry),
  .tail_entry_i (rsp_o.tail_entry),
  .entry_count_i(rsp_o.entry_count),
  .list_empty_i (rsp_o.list_empty),
  .misuse_flag_i(rsp_o.misuse_flag)
);
